[design/assert_macros.svh]
// assertion helpers used by the rtl file trimmed_rolling_mean
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define TRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TRM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/trm_pkg.sv]
`default_nettype none

package trm_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int PORTION_W  = 9;
    localparam int FRAC_SH    = 8;
    localparam int ROUND_HALF = 128;
    localparam logic [PORTION_W-1:0] PORTION_RESET = 9'd230;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OLD,
        S_RM,
        S_INS,
        S_INS_LAST,
        S_SUM,
        S_DIV
    } t_state;

    typedef struct packed {
        logic busy;
    } t_div_st;

endpackage

`default_nettype wire

[design/trm_ram.sv]
`default_nettype none

module trm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

[design/trm_div.sv]
`default_nettype none

module trm_div #(
    parameter int NW = 38,
    parameter int DW = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [NW-1:0] i_num,
    input  wire logic        [DW-1:0] i_den,
    output logic             [NW-1:0] o_quot,
    output trm_pkg::t_div_st          o_st
);

    import trm_pkg::*;

    localparam int KW = $clog2(NW + 1);

    logic          r_busy, n_busy;
    logic [KW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_q, n_q;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_den, n_den;
    logic          r_neg, n_neg;
    logic [DW:0]   w_trial;

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_den   = r_den;
        n_neg   = r_neg;
        w_trial = {r_rem, r_q[NW-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = KW'(NW);
            n_neg  = i_num[NW-1];
            n_q    = i_num[NW-1] ? (NW'(0) - NW'(i_num)) : NW'(i_num);
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = DW'(w_trial - {1'b0, r_den});
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DW-1:0];
                n_q   = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - KW'(1);
            if (r_cnt == KW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_quot  = r_neg ? (NW'(0) - r_q) : r_q;
    assign o_st.busy = r_busy;

endmodule

`default_nettype wire

[design/trimmed_rolling_mean.sv]
// channel   dir  tdata fields (low bit up)           tuser  tlast
// s         in   sample[31:0]                        -      -
// m         out  trimmed_mean[31:0], held_count      -      -
// cfg       in   keep_portion[8:0], write on wr_en   -      -
//
// one transfer at a time, worked through in these steps
// (old-sample read, removal walk and insertion walk over the sorted memory,
// sum walk over the kept rank range, then a one-bit-per-cycle divider)
// reset is synchronous, active low; the memories need no clearing pass
// a finished result waits in the output register while the next transfer
// is taken; the divider result waits if that register is still full
`default_nettype none
`include "assert_macros.svh"

module trimmed_rolling_mean #(
    parameter int WINDOW = 64,
    localparam int CW = $clog2(WINDOW + 1),
    localparam int OW = ((32 + CW + 7) / 8) * 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [31:0]                    i_s_tdata,  // sample
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [OW-1:0]                       o_m_tdata,  // trimmed_mean, held_count
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [trm_pkg::PORTION_W-1:0]  i_cfg_wr_data
);

    import trm_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam int SW = SAMPLE_W + AW;
    localparam int PW = PORTION_W + CW + 1;
    localparam int UW = PW - FRAC_SH;

    t_state r_state, n_state;

    logic [PORTION_W-1:0]       r_port;
    logic [AW-1:0]              r_slot, n_slot;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic signed [SW-1:0]       r_total, n_total;
    logic signed [SAMPLE_W-1:0] r_s, n_s;
    logic [SAMPLE_W-1:0]        r_old, n_old;
    logic [AW-1:0]              r_k, n_k;
    logic                       r_kv, n_kv;
    logic [AW-1:0]              r_j, n_j;
    logic                       r_rv, n_rv;
    logic                       r_found, n_found;
    logic [AW-1:0]              r_end, n_end;
    logic [CW-1:0]              r_d, n_d;
    logic signed [SW-1:0]       r_acc, n_acc;
    logic                       r_ovalid, n_ovalid;
    logic [SAMPLE_W-1:0]        r_omean, n_omean;
    logic [CW-1:0]              r_ocnt, n_ocnt;

    logic                win_we;
    logic [AW-1:0]       win_waddr, win_raddr;
    logic [SAMPLE_W-1:0] win_rdata;
    logic                srt_we;
    logic [AW-1:0]       srt_waddr, srt_raddr;
    logic [SAMPLE_W-1:0] srt_wdata, srt_rdata;

    logic          div_start;
    logic [SW-1:0] div_quot;
    t_div_st       div_st;

    logic          w_accept, w_full, w_trim, w_load;
    logic [PW-1:0] w_prod;
    logic [UW-1:0] w_u;
    logic [CW-1:0] w_c, w_lo, w_d, w_last;
    logic [CW:0]   w_c1;
    logic signed [SAMPLE_W-1:0] w_x;

    trm_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW)) u_win (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (win_waddr),
        .i_wdata (r_s),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    trm_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW)) u_srt (
        .i_clk   (i_clk),
        .i_we    (srt_we),
        .i_waddr (srt_waddr),
        .i_wdata (srt_wdata),
        .i_raddr (srt_raddr),
        .o_rdata (srt_rdata)
    );

    trm_div #(.NW(SW), .DW(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_acc),
        .i_den   (r_d),
        .o_quot  (div_quot),
        .o_st    (div_st)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_cnt == CW'(WINDOW));
    assign w_x        = signed'(srt_rdata);
    assign w_load     = (r_state == S_DIV) && !div_st.busy && (!r_ovalid || i_m_tready);

    // kept count and rank range over the held samples
    always_comb begin
        w_prod = PW'(r_port) * PW'(r_cnt) + PW'(ROUND_HALF);
        w_u    = w_prod[PW-1:FRAC_SH];
        if (w_u == '0) begin
            w_u = UW'(1);
        end
        w_trim = (w_u < UW'(r_cnt));
        w_c    = w_trim ? (r_cnt - CW'(w_u)) : '0;
        w_c1   = {1'b0, w_c} + (CW + 1)'(1);
        w_lo   = w_c1[CW:1];
        w_d    = w_trim ? CW'(w_u) : r_cnt;
        w_last = w_lo + w_d - CW'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_OLD;
                end
            end
            S_OLD: begin
                if (w_full) begin
                    n_state = S_RM;
                end else if (r_cnt == '0) begin
                    n_state = S_INS_LAST;
                end else begin
                    n_state = S_INS;
                end
            end
            S_RM: begin
                if (r_rv && r_j == AW'(WINDOW - 1)) begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                if (r_rv) begin
                    if (w_x > r_s) begin
                        if (r_j == '0) begin
                            n_state = S_INS_LAST;
                        end
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_INS_LAST: n_state = S_SUM;
            S_SUM: begin
                if (r_rv && r_j == r_end) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_slot    = r_slot;
        n_cnt     = r_cnt;
        n_total   = r_total;
        n_s       = r_s;
        n_old     = r_old;
        n_k       = r_k;
        n_kv      = r_kv;
        n_j       = r_j;
        n_rv      = 1'b0;
        n_found   = r_found;
        n_end     = r_end;
        n_d       = r_d;
        n_acc     = r_acc;
        n_ovalid  = (r_ovalid && i_m_tready) ? 1'b0 : r_ovalid;
        n_omean   = r_omean;
        n_ocnt    = r_ocnt;
        win_we    = 1'b0;
        win_waddr = r_slot;
        win_raddr = r_slot;
        srt_we    = 1'b0;
        srt_waddr = '0;
        srt_wdata = r_s;
        srt_raddr = r_k;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_s = signed'(i_s_tdata);
                end
            end
            S_OLD: begin
                win_we  = 1'b1;
                n_old   = win_rdata;
                n_total = r_total + SW'(r_s)
                        - (w_full ? SW'(signed'(win_rdata)) : SW'(0));
                n_slot  = (r_slot == AW'(WINDOW - 1)) ? '0 : r_slot + AW'(1);
                n_found = 1'b0;
                n_kv    = 1'b1;
                if (w_full) begin
                    n_k = '0;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                    n_k   = AW'(r_cnt - CW'(1));
                end
            end
            S_RM: begin
                if (r_kv) begin
                    n_rv = 1'b1;
                    n_j  = r_k;
                    if (r_k == AW'(WINDOW - 1)) begin
                        n_kv = 1'b0;
                    end else begin
                        n_k = r_k + AW'(1);
                    end
                end
                if (r_rv) begin
                    if (!r_found) begin
                        if (srt_rdata == r_old) begin
                            n_found = 1'b1;
                        end
                    end else begin
                        srt_we    = 1'b1;
                        srt_waddr = r_j - AW'(1);
                        srt_wdata = srt_rdata;
                    end
                    if (r_j == AW'(WINDOW - 1)) begin
                        n_rv = 1'b0;
                        n_kv = 1'b1;
                        n_k  = AW'(WINDOW - 2);
                    end
                end
            end
            S_INS: begin
                if (r_kv) begin
                    n_rv = 1'b1;
                    n_j  = r_k;
                    if (r_k == '0) begin
                        n_kv = 1'b0;
                    end else begin
                        n_k = r_k - AW'(1);
                    end
                end
                if (r_rv) begin
                    srt_we    = 1'b1;
                    srt_waddr = r_j + AW'(1);
                    if (w_x > r_s) begin
                        srt_wdata = srt_rdata;
                        if (r_j == '0) begin
                            n_rv = 1'b0;
                        end
                    end else begin
                        n_rv  = 1'b0;
                        n_k   = AW'(w_lo);
                        n_kv  = 1'b1;
                        n_end = AW'(w_last);
                        n_d   = w_d;
                        n_acc = '0;
                    end
                end
            end
            S_INS_LAST: begin
                srt_we    = 1'b1;
                srt_waddr = '0;
                n_k       = AW'(w_lo);
                n_kv      = 1'b1;
                n_end     = AW'(w_last);
                n_d       = w_d;
                n_acc     = '0;
            end
            S_SUM: begin
                if (r_kv) begin
                    n_rv = 1'b1;
                    n_j  = r_k;
                    if (r_k == r_end) begin
                        n_kv = 1'b0;
                    end else begin
                        n_k = r_k + AW'(1);
                    end
                end
                if (r_rv) begin
                    n_acc = r_acc + SW'(w_x);
                    if (r_j == r_end) begin
                        n_rv      = 1'b0;
                        div_start = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_omean  = div_quot[SAMPLE_W-1:0];
                    n_ocnt   = r_cnt;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_port   <= PORTION_RESET;
            r_slot   <= '0;
            r_cnt    <= '0;
            r_total  <= '0;
            r_kv     <= 1'b0;
            r_rv     <= 1'b0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_wr_en) begin
                r_port <= i_cfg_wr_data;
            end
            r_slot   <= n_slot;
            r_cnt    <= n_cnt;
            r_total  <= n_total;
            r_kv     <= n_kv;
            r_rv     <= n_rv;
            r_found  <= n_found;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s     <= n_s;
        r_old   <= n_old;
        r_k     <= n_k;
        r_j     <= n_j;
        r_end   <= n_end;
        r_d     <= n_d;
        r_acc   <= n_acc;
        r_omean <= n_omean;
        r_ocnt  <= n_ocnt;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = OW'({r_ocnt, r_omean});

    `TRM_ASSERT(a_cnt_bound, r_cnt <= CW'(WINDOW), "fill count above window size")
    `TRM_ASSERT(a_accept_reads_old, w_accept |=> r_state == S_OLD, "accept did not start update")
    `TRM_ASSERT(a_div_idle_at_start, div_start |-> !div_st.busy, "divider restarted while busy")
    `TRM_ASSERT(a_out_count, o_m_tvalid |-> r_ocnt != '0, "result with empty window")

endmodule

`default_nettype wire
